FILE: src/tes_pkg.sv
// Shared types and constants of the constant strain triangle stiffness block.
package tes_pkg;

  // Widths of the configuration write port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgModulus   = 2'd0,
    CfgPoisson   = 2'd1,
    CfgPlaneMode = 2'd2,
    CfgThickness = 2'd3
  } cfg_reg_e;

  // Elasticity model selected by the plane mode register.
  typedef enum logic {
    PlaneStress = 1'b0,
    PlaneStrain = 1'b1
  } plane_mode_e;

  // Register values after reset.
  localparam logic [31:0] ResetModulus   = 32'd210000;
  localparam logic [14:0] ResetPoisson   = 15'd19661;
  localparam logic        ResetPlaneMode = 1'b0;
  localparam logic [31:0] ResetThickness = 32'd65536;

  // Entries per triangle, the last degree of freedom and arithmetic widths.
  localparam int unsigned EntryCount = 21;
  localparam int unsigned GapW       = $clog2(EntryCount);
  localparam logic [2:0]  LastDof    = 3'd5;
  localparam int unsigned DvW        = 100;
  localparam int unsigned QuoW       = 64;
  localparam int unsigned RemW       = QuoW + DvW;

  // One triangle: three corners in signed Q16.16.
  typedef struct packed {
    logic signed [31:0] node0_x;
    logic signed [31:0] node0_y;
    logic signed [31:0] node1_x;
    logic signed [31:0] node1_y;
    logic signed [31:0] node2_x;
    logic signed [31:0] node2_y;
  } tri_item_t;

  // One stiffness entry.
  typedef struct packed {
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [63:0] entry_value;
    logic               last_entry;
    logic               degenerate;
    logic               saturated;
  } stiff_entry_t;

endpackage

FILE: src/triangle_element_stiffness.sv
// Constant strain triangle stiffness: setup pipeline, entry sequencer and entry pipeline.
//
//  channel   | signals                           | transaction
//  ----------+-----------------------------------+------------------------------------
//  triangle  | start, busy, item_i               | accepted when start && !busy
//  entry     | result_valid_o, result_o          | one cycle strobe, always taken
//  config    | cfg_we_i, cfg_index_i, cfg_data_i | written when cfg_we_i is high
//
// busy rises after each accepted transaction and stays high while the gap counter
// runs down, set by the 21 upper-triangle entries leaving one a cycle.
// Each triangle passes the setup pipeline into the entry sequencer; each entry then
// passes the entry pipeline and the 64 one-bit stages of the restoring divider.
// A degenerate triangle gives one entry and still occupies its full acceptance slot.
// Reset clears the valid bits and loads the register defaults; the receiver cannot stall.
module triangle_element_stiffness (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  tes_pkg::tri_item_t                 item_i,
  input  logic                               cfg_we_i,
  input  logic [tes_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tes_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                               result_valid_o,
  output tes_pkg::stiff_entry_t              result_o
);

  localparam int unsigned DvW  = tes_pkg::DvW;
  localparam int unsigned QuoW = tes_pkg::QuoW;
  localparam int unsigned RemW = tes_pkg::RemW;

  // Shape function gradients of one triangle.
  typedef struct packed {
    logic signed [32:0] bx0;
    logic signed [32:0] bx1;
    logic signed [32:0] bx2;
    logic signed [32:0] cy0;
    logic signed [32:0] cy1;
    logic signed [32:0] cy2;
  } grad_t;

  // Bookkeeping that travels with each entry.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
    logic       degen;
  } tag_t;

  function automatic logic signed [32:0] sdiff(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // Gradient of one node: c (d/dy) when use_c is set, else b (d/dx).
  function automatic logic signed [32:0] pick(input grad_t g, input logic [1:0] node,
                                              input logic use_c);
    logic signed [32:0] r;
    unique case (node)
      2'd0:    r = use_c ? g.cy0 : g.bx0;
      2'd1:    r = use_c ? g.cy1 : g.bx1;
      default: r = use_c ? g.cy2 : g.bx2;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  logic [31:0] youngs_q;
  logic [14:0] poisson_q;
  logic        plane_q;
  logic [31:0] thick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      youngs_q  <= tes_pkg::ResetModulus;
      poisson_q <= tes_pkg::ResetPoisson;
      plane_q   <= tes_pkg::ResetPlaneMode;
      thick_q   <= tes_pkg::ResetThickness;
    end else if (cfg_we_i) begin
      unique case (tes_pkg::cfg_reg_e'(cfg_index_i))
        tes_pkg::CfgModulus:   youngs_q  <= cfg_data_i[31:0];
        tes_pkg::CfgPoisson:   poisson_q <= cfg_data_i[14:0];
        tes_pkg::CfgPlaneMode: plane_q   <= cfg_data_i[0];
        tes_pkg::CfgThickness: thick_q   <= cfg_data_i[31:0];
      endcase
    end
  end

  // Elasticity factors derived from the registers, refreshed every cycle.
  logic [17:0] md_d, mo_d;
  logic [16:0] ms_d;
  logic [33:0] den_d;
  logic [17:0] md_q, mo_q;
  logic [16:0] ms_q;
  logic [33:0] den_q;
  logic [63:0] te_q;

  always_comb begin
    logic [29:0] uu;
    logic [16:0] sp, sm;
    logic [33:0] strain_prod;
    uu          = 30'(poisson_q) * 30'(poisson_q);
    sp          = 17'd65536 + {2'b00, poisson_q};
    sm          = 17'd65536 - {1'b0, poisson_q, 1'b0};
    strain_prod = 34'(sp) * 34'(sm);
    mo_d        = {2'b00, poisson_q, 1'b0};
    if (tes_pkg::plane_mode_e'(plane_q) == tes_pkg::PlaneStrain) begin
      md_d  = {1'b0, 17'd65536 - {2'b00, poisson_q}} << 1;
      ms_d  = sm;
      den_d = strain_prod << 1;
    end else begin
      md_d  = 18'd131072;
      ms_d  = 17'd65536 - {2'b00, poisson_q};
      den_d = (34'd4294967296 - {4'b0000, uu}) << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    md_q  <= md_d;
    mo_q  <= mo_d;
    ms_q  <= ms_d;
    den_q <= den_d;
    te_q  <= 64'(thick_q) * 64'(youngs_q);
  end

  // ---------------------------------------------------------------------------
  // Acceptance spacing: one triangle per entry slot window.
  logic                      accept;
  logic [tes_pkg::GapW-1:0]  gap_q;

  assign busy   = (gap_q != '0);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= tes_pkg::GapW'(tes_pkg::EntryCount - 1);
    end else if (gap_q != '0) begin
      gap_q <= gap_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Setup pipeline: corner differences, twice the area and the divisor.
  logic               a0_v_q, a1_v_q, a2_v_q, a3_v_q, a4_v_q, a5_v_q, a6_v_q;
  tes_pkg::tri_item_t a0_q;
  logic signed [32:0] a1_dx1_q, a1_dy2_q, a1_dx2_q, a1_dy1_q;
  logic signed [65:0] a2_t1_q, a2_t2_q;
  logic signed [66:0] a3_t_q;
  logic [65:0]        a4_tabs_q;
  logic               a4_degen_q, a5_degen_q, a6_degen_q;
  logic [65:0]        a5_lo_q;
  logic [67:0]        a5_hi_q;
  logic [DvW-1:0]     a6_dv_q;
  grad_t              grad_q [1:6];
  grad_t              grad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_v_q <= 1'b0;
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      a3_v_q <= 1'b0;
      a4_v_q <= 1'b0;
      a5_v_q <= 1'b0;
      a6_v_q <= 1'b0;
    end else begin
      a0_v_q <= accept;
      a1_v_q <= a0_v_q;
      a2_v_q <= a1_v_q;
      a3_v_q <= a2_v_q;
      a4_v_q <= a3_v_q;
      a5_v_q <= a4_v_q;
      a6_v_q <= a5_v_q;
    end
  end

  always_comb begin
    grad_d.bx0 = sdiff(a0_q.node1_y, a0_q.node2_y);
    grad_d.bx1 = sdiff(a0_q.node2_y, a0_q.node0_y);
    grad_d.bx2 = sdiff(a0_q.node0_y, a0_q.node1_y);
    grad_d.cy0 = sdiff(a0_q.node2_x, a0_q.node1_x);
    grad_d.cy1 = sdiff(a0_q.node0_x, a0_q.node2_x);
    grad_d.cy2 = sdiff(a0_q.node1_x, a0_q.node0_x);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a0_q <= item_i;
    end
    a1_dx1_q  <= sdiff(a0_q.node1_x, a0_q.node0_x);
    a1_dy2_q  <= sdiff(a0_q.node2_y, a0_q.node0_y);
    a1_dx2_q  <= sdiff(a0_q.node2_x, a0_q.node0_x);
    a1_dy1_q  <= sdiff(a0_q.node1_y, a0_q.node0_y);
    grad_q[1] <= grad_d;
    for (int k = 2; k <= 6; k++) begin
      grad_q[k] <= grad_q[k-1];
    end
    a2_t1_q    <= a1_dx1_q * a1_dy2_q;
    a2_t2_q    <= a1_dx2_q * a1_dy1_q;
    a3_t_q     <= 67'(a2_t1_q) - 67'(a2_t2_q);
    a4_tabs_q  <= a3_t_q[66] ? 66'(-a3_t_q) : 66'(a3_t_q);
    a4_degen_q <= (a3_t_q == '0);
    a5_lo_q    <= 66'(a4_tabs_q[31:0]) * 66'(den_q);
    a5_hi_q    <= 68'(a4_tabs_q[65:32]) * 68'(den_q);
    a5_degen_q <= a4_degen_q;
    a6_dv_q    <= DvW'(a5_lo_q) + (DvW'(a5_hi_q) << 32);
    a6_degen_q <= a5_degen_q;
  end

  // ---------------------------------------------------------------------------
  // Entry sequencer: walks the upper triangle in row order, one entry a cycle.
  logic           seq_act_q;
  logic [2:0]     row_q, col_q;
  grad_t          ctx_g_q;
  logic [DvW-1:0] ctx_dv_q;
  logic           ctx_degen_q;
  logic           seq_last;

  assign seq_last = (row_q == tes_pkg::LastDof) && (col_q == tes_pkg::LastDof);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_act_q <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
    end else if (a6_v_q) begin
      seq_act_q <= 1'b1;
      row_q     <= '0;
      col_q     <= '0;
    end else if (seq_act_q) begin
      if (ctx_degen_q || seq_last) begin
        seq_act_q <= 1'b0;
      end else if (col_q == tes_pkg::LastDof) begin
        // The next row starts on its diagonal.
        row_q <= row_q + 3'd1;
        col_q <= row_q + 3'd1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a6_v_q) begin
      ctx_g_q     <= grad_q[6];
      ctx_dv_q    <= a6_dv_q;
      ctx_degen_q <= a6_degen_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry pipeline, stages 0 to 9: builds the numerator of each entry.
  logic           ep_v_q   [0:9];
  tag_t           ep_tag_q [0:9];
  logic [DvW-1:0] ep_dv_q  [0:9];
  logic           ep_neg_q [5:9];
  tag_t           tag0_d;

  logic signed [32:0] fa_d, fb_d, ga_d, gb_d;
  logic [31:0]        e0_fam_q, e0_fbm_q, e0_gam_q, e0_gbm_q;
  logic [17:0]        e0_kd_q;
  logic               e0_s1_q, e0_s2_q, e1_s1_q, e1_s2_q, e2_s1_q, e2_s2_q, e3_s1_q, e3_s2_q;
  logic [49:0]        e1_pa_q;
  logic [48:0]        e1_pg_q;
  logic [31:0]        e1_fbm_q, e1_gbm_q;
  logic [56:0]        e2_alo_q, e2_ahi_q, e2_glo_q;
  logic [55:0]        e2_ghi_q;
  logic [81:0]        e3_a_q, e3_g_q;
  logic signed [83:0] e4_v_q;
  logic [82:0]        e5_qm_q;
  logic [59:0]        e6_p_q [2][3];
  logic [91:0]        e7_g_q [3];
  logic [119:0]       e8_h_q;
  logic [91:0]        e8_g2_q;
  logic [147:0]       e9_num_q;
  logic signed [83:0] sa_d, sg_d;
  logic [83:0]        qm_pad;

  always_comb begin
    fa_d         = pick(ctx_g_q, row_q[2:1], row_q[0]);
    ga_d         = pick(ctx_g_q, row_q[2:1], !row_q[0]);
    fb_d         = pick(ctx_g_q, col_q[2:1], col_q[0]);
    gb_d         = pick(ctx_g_q, col_q[2:1], !col_q[0]);
    tag0_d.row   = row_q;
    tag0_d.col   = col_q;
    tag0_d.last  = ctx_degen_q || seq_last;
    tag0_d.degen = ctx_degen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= 9; k++) begin
        ep_v_q[k] <= 1'b0;
      end
    end else begin
      ep_v_q[0] <= seq_act_q;
      for (int k = 1; k <= 9; k++) begin
        ep_v_q[k] <= ep_v_q[k-1];
      end
    end
  end

  // Signed sum of the two product terms.
  always_comb begin
    sa_d = $signed({2'b00, e3_a_q});
    sg_d = $signed({2'b00, e3_g_q});
    if (e3_s1_q) begin
      sa_d = -sa_d;
    end
    if (e3_s2_q) begin
      sg_d = -sg_d;
    end
    qm_pad = {1'b0, e5_qm_q};
  end

  always_ff @(posedge clk_i) begin
    ep_tag_q[0] <= tag0_d;
    ep_dv_q[0]  <= ctx_dv_q;
    for (int k = 1; k <= 9; k++) begin
      ep_tag_q[k] <= ep_tag_q[k-1];
      ep_dv_q[k]  <= ep_dv_q[k-1];
    end
    for (int k = 6; k <= 9; k++) begin
      ep_neg_q[k] <= ep_neg_q[k-1];
    end
    // Gradient pick and magnitudes.
    e0_fam_q <= mag33(fa_d);
    e0_fbm_q <= mag33(fb_d);
    e0_gam_q <= mag33(ga_d);
    e0_gbm_q <= mag33(gb_d);
    e0_kd_q  <= (row_q[0] == col_q[0]) ? md_q : mo_q;
    e0_s1_q  <= fa_d[32] ^ fb_d[32];
    e0_s2_q  <= ga_d[32] ^ gb_d[32];
    // Gradient times elasticity factor.
    e1_pa_q  <= 50'(e0_fam_q) * 50'(e0_kd_q);
    e1_pg_q  <= 49'(e0_gam_q) * 49'(ms_q);
    e1_fbm_q <= e0_fbm_q;
    e1_gbm_q <= e0_gbm_q;
    e1_s1_q  <= e0_s1_q;
    e1_s2_q  <= e0_s2_q;
    // Partial products with the second gradient.
    e2_alo_q <= 57'(e1_pa_q[24:0]) * 57'(e1_fbm_q);
    e2_ahi_q <= 57'(e1_pa_q[49:25]) * 57'(e1_fbm_q);
    e2_glo_q <= 57'(e1_pg_q[24:0]) * 57'(e1_gbm_q);
    e2_ghi_q <= 56'(e1_pg_q[48:25]) * 56'(e1_gbm_q);
    e2_s1_q  <= e1_s1_q;
    e2_s2_q  <= e1_s2_q;
    e3_a_q   <= 82'(e2_alo_q) + (82'(e2_ahi_q) << 25);
    e3_g_q   <= 82'(e2_glo_q) + (82'(e2_ghi_q) << 25);
    e3_s1_q  <= e2_s1_q;
    e3_s2_q  <= e2_s2_q;
    e4_v_q   <= sa_d + sg_d;
    // Magnitude and sign of the material product.
    e5_qm_q     <= e4_v_q[83] ? 83'(-e4_v_q) : 83'(e4_v_q);
    ep_neg_q[5] <= e4_v_q[83];
    // Numerator: thickness times modulus times the material product.
    for (int h = 0; h < 2; h++) begin
      for (int k = 0; k < 3; k++) begin
        e6_p_q[h][k] <= 60'(te_q[32*h +: 32]) * 60'(qm_pad[28*k +: 28]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      e7_g_q[k] <= 92'(e6_p_q[0][k]) + (92'(e6_p_q[1][k]) << 32);
    end
    e8_h_q   <= 120'(e7_g_q[0]) + (120'(e7_g_q[1]) << 28);
    e8_g2_q  <= e7_g_q[2];
    e9_num_q <= 148'(e8_h_q) + (148'(e8_g2_q) << 56);
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: overflow check, then one quotient bit per stage.
  logic            div_v_q   [0:QuoW];
  tag_t            div_tag_q [0:QuoW];
  logic            div_neg_q [0:QuoW];
  logic            div_big_q [0:QuoW];
  logic [DvW-1:0]  div_dv_q  [0:QuoW];
  logic [RemW-1:0] div_r_q   [0:QuoW];
  logic [QuoW-1:0] div_quo_q [0:QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else begin
      div_v_q[0] <= ep_v_q[9];
    end
  end

  // The numerator carries an extra factor of 2^31; a quotient of 2^64 or more saturates.
  always_ff @(posedge clk_i) begin
    div_tag_q[0] <= ep_tag_q[9];
    div_neg_q[0] <= ep_neg_q[9];
    div_dv_q[0]  <= ep_dv_q[9];
    div_big_q[0] <= (e9_num_q[147:33] >= 115'(ep_dv_q[9]));
    div_r_q[0]   <= {e9_num_q[132:0], 31'd0};
    div_quo_q[0] <= '0;
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_div
    localparam int unsigned Bit = QuoW - 1 - s;
    logic [DvW:0]    slice_d, diff_d;
    logic            ge_d;
    logic [RemW-1:0] r_d;

    // Trial subtraction of the divisor at this bit position.
    always_comb begin
      slice_d = div_r_q[s][Bit+DvW -: DvW+1];
      diff_d  = slice_d - {1'b0, div_dv_q[s]};
      ge_d    = (slice_d >= {1'b0, div_dv_q[s]});
      r_d     = div_r_q[s];
      if (ge_d) begin
        r_d[Bit+DvW -: DvW+1] = diff_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[s+1] <= 1'b0;
      end else begin
        div_v_q[s+1] <= div_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      div_tag_q[s+1] <= div_tag_q[s];
      div_neg_q[s+1] <= div_neg_q[s];
      div_big_q[s+1] <= div_big_q[s];
      div_dv_q[s+1]  <= div_dv_q[s];
      div_r_q[s+1]   <= r_d;
      div_quo_q[s+1] <= {div_quo_q[s][QuoW-2:0], ge_d};
    end
  end

  // ---------------------------------------------------------------------------
  // Rounding to nearest, ties away from zero, on the magnitude.
  logic        rd_v_q;
  tag_t        rd_tag_q;
  logic        rd_neg_q, rd_big_q;
  logic [64:0] rd_q;
  logic        rnd_d;

  assign rnd_d = ({div_r_q[QuoW][DvW-1:0], 1'b0} >= {1'b0, div_dv_q[QuoW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= div_v_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= div_tag_q[QuoW];
    rd_neg_q <= div_neg_q[QuoW];
    rd_big_q <= div_big_q[QuoW];
    rd_q     <= {1'b0, div_quo_q[QuoW]} + 65'(rnd_d);
  end

  // ---------------------------------------------------------------------------
  // Saturation, sign and the output register.
  logic                  res_v_q;
  tes_pkg::stiff_entry_t res_q, res_d;

  always_comb begin
    logic sat;
    sat = rd_big_q || (rd_neg_q ? (rd_q > 65'h0_8000_0000_0000_0000)
                                : (rd_q > 65'h0_7FFF_FFFF_FFFF_FFFF));
    res_d.row_index  = rd_tag_q.row;
    res_d.col_index  = rd_tag_q.col;
    res_d.last_entry = rd_tag_q.last;
    res_d.degenerate = rd_tag_q.degen;
    res_d.saturated  = sat;
    if (sat) begin
      res_d.entry_value = rd_neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      res_d.entry_value = rd_neg_q ? -$signed(rd_q[63:0]) : $signed(rd_q[63:0]);
    end
    if (rd_tag_q.degen) begin
      res_d.entry_value = '0;
      res_d.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

FILE: src/tes_checker.sv
// Port-level checks of the triangle stiffness block and their binding.
module tes_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  result_valid_o,
  input tes_pkg::stiff_entry_t result_o
);

  // An accepted transaction blocks the next one in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("busy did not rise after an accepted triangle");

  // A degenerate triangle gives a single zero entry that closes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate |->
      result_o.last_entry && (result_o.entry_value == 64'sd0) && !result_o.saturated)
    else $error("degenerate entry is not a closing zero entry");

  // Entries stay in the upper triangle of the 6x6 matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_o.col_index >= result_o.row_index) && (result_o.col_index <= 3'd5))
    else $error("entry outside the upper triangle");

  // The closing entry of a regular triangle is the last diagonal entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_entry && !result_o.degenerate |->
      (result_o.row_index == 3'd5) && (result_o.col_index == 3'd5))
    else $error("closing entry is not row 5, column 5");

endmodule

bind triangle_element_stiffness tes_checker u_tes_checker (.*);
